// ===== sv/mrot_pkg.sv =====
package mrot_pkg;

  localparam int CHANNELS  = 8;
  localparam int TIME_BITS = 32;

  // width of the shared subtractor, wide enough for clock and timer length
  localparam int CMP_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int IDX_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_BITS  = $clog2(CHANNELS + 1);

  localparam logic [2:0] CMD_SET_ONE = 3'd0;
  localparam logic [2:0] CMD_SET_ALL = 3'd1;
  localparam logic [2:0] CMD_START   = 3'd2;
  localparam logic [2:0] CMD_TICK    = 3'd3;
  localparam logic [2:0] CMD_STATUS  = 3'd4;

  localparam logic [1:0] EV_DONE     = 2'd0;
  localparam logic [1:0] EV_EXPIRED  = 2'd1;
  localparam logic [1:0] EV_STATUS   = 2'd2;
  localparam logic [1:0] EV_INVALID  = 2'd3;

endpackage

// ===== sv/mrot_in_if.sv =====
interface mrot_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  channel;
  logic        set_on;
  logic [31:0] period_ms;
  logic        run_level;

  modport source (output valid, command, channel, set_on, period_ms, run_level,
                  input ready);
  modport sink   (input valid, command, channel, set_on, period_ms, run_level,
                  output ready);
endinterface

// ===== sv/mrot_out_if.sv =====
interface mrot_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  relay_drive;
  logic [3:0]  report_channel;
  logic [1:0]  event_res;
  logic        channel_on;
  logic        timer_running;
  logic [31:0] remaining_ms;
  logic [3:0]  changes;
  logic        last;

  modport source (output valid, relay_drive, report_channel, event_res, channel_on,
                  timer_running, remaining_ms, changes, last,
                  input ready);
  modport sink   (input valid, relay_drive, report_channel, event_res, channel_on,
                  timer_running, remaining_ms, changes, last,
                  output ready);
endinterface

// ===== sv/mrot_sub.sv =====
module mrot_sub
  import mrot_pkg::*;
(
  input  logic [CMP_BITS-1:0] a,
  input  logic [CMP_BITS-1:0] b,
  output logic [CMP_BITS-1:0] diff,
  output logic                borrow
);

  logic [CMP_BITS:0] full;

  // borrow set means b > a
  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[CMP_BITS-1:0];
  assign borrow = full[CMP_BITS];

endmodule

// ===== sv/multichannel_relay_oneshot_timer_core.sv =====
// relay controller with one-shot timers, one channel of requests in and one of
// results out, both valid/ready; a request is taken when valid and ready are high
// ready is high only while the sequencer is idle, so requests are handled one by one
// set one, set all, start timer, status of a stopped timer and invalid-channel
// requests: one result, pushed straight from decode; undefined commands give none
// status of a running timer: one result, after one pass through the shared
// subtractor (elapsed, then length minus elapsed)
// tick: decode, a sweep through the one shared subtractor (elapsed, then length
// minus elapsed, per channel), then a scan of the channel indices up to the highest
// expired one, with one result pushed per expired channel; a tick with no
// expiry gives no result and goes back to idle once the sweep is done
// the last result of a request carries last
// results go through an output register; a stalled receiver holds the sequencer
// at its next result, though a new request can be taken while the last one waits
// reset clears the millisecond clock, every timer and every relay
module multichannel_relay_oneshot_timer_core
  import mrot_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mrot_in_if.sink    request,
  mrot_out_if.source result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ELAPSED,
    S_DIFF,
    S_EMIT,
    S_PUSH
  } state_t;

  localparam logic [4:0] CH_COUNT = 5'(CHANNELS);

  state_t state;
  state_t ret_state;

  logic [2:0]  cmd_q;
  logic [3:0]  ch_q;
  logic        set_on_q;
  logic [31:0] dur_q;
  logic        run_level_q;

  logic [TIME_BITS-1:0] now;
  logic [CHANNELS-1:0]  timing_active;
  logic [CHANNELS-1:0]  start_level;
  logic [CHANNELS-1:0]  energized;
  logic [TIME_BITS-1:0] start_ms     [CHANNELS];
  logic [31:0]          timer_length [CHANNELS];

  logic [IDX_BITS-1:0]  idx;
  logic [CHANNELS-1:0]  mask;
  logic [TIME_BITS-1:0] elapsed;

  // staged result
  logic [3:0]  res_ch;
  logic [1:0]  res_ev;
  logic        res_on;
  logic        res_run;
  logic [31:0] res_rem;
  logic [3:0]  res_chg;
  logic        res_last;

  logic        out_valid;
  logic [7:0]  out_drive;
  logic [3:0]  out_ch;
  logic [1:0]  out_ev;
  logic        out_on;
  logic        out_run;
  logic [31:0] out_rem;
  logic [3:0]  out_chg;
  logic        out_last;

  logic [CMP_BITS-1:0] alu_a;
  logic [CMP_BITS-1:0] alu_b;
  logic [CMP_BITS-1:0] alu_diff;
  logic                alu_borrow;

  logic                ch_valid;
  logic [IDX_BITS-1:0] ch_idx;
  logic [CHANNELS-1:0] sel_bit;
  logic [CNT_BITS-1:0] all_chg;
  logic [7:0]          drive;

  assign ch_valid = {1'b0, ch_q} < CH_COUNT;
  assign ch_idx   = ch_q[IDX_BITS-1:0];
  assign sel_bit  = CHANNELS'(1) << idx;
  assign all_chg  = CNT_BITS'($countones(energized ^ {CHANNELS{set_on_q}}));

  always_comb begin
    drive = 8'hFF;
    for (int i = 0; i < CHANNELS && i < 8; i++) begin
      drive[i] = ~energized[i];
    end
  end

  // shared unit: now - start in the first step, length - elapsed in the second
  always_comb begin
    if (state == S_ELAPSED) begin
      alu_a = CMP_BITS'(now);
      alu_b = CMP_BITS'(start_ms[idx]);
    end else begin
      alu_a = CMP_BITS'(timer_length[idx]);
      alu_b = CMP_BITS'(elapsed);
    end
  end

  mrot_sub u_sub (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  assign request.ready         = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.relay_drive    = out_drive;
  assign result.report_channel = out_ch;
  assign result.event_res      = out_ev;
  assign result.channel_on     = out_on;
  assign result.timer_running  = out_run;
  assign result.remaining_ms   = out_rem;
  assign result.changes        = out_chg;
  assign result.last           = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret_state     <= S_IDLE;
      now           <= '0;
      timing_active <= '0;
      energized     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && result.ready && state != S_PUSH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (request.valid) begin
            cmd_q       <= request.command;
            ch_q        <= request.channel;
            set_on_q    <= request.set_on;
            dur_q       <= request.period_ms;
            run_level_q <= request.run_level;
            state       <= S_DECODE;
          end
        end

        S_DECODE: begin
          res_ch    <= ch_q;
          res_ev    <= EV_INVALID;
          res_on    <= 1'b0;
          res_run   <= 1'b0;
          res_rem   <= '0;
          res_chg   <= '0;
          res_last  <= 1'b1;
          ret_state <= S_IDLE;
          state     <= S_PUSH;
          case (cmd_q)
            CMD_SET_ONE: begin
              if (ch_valid) begin
                timing_active[ch_idx] <= 1'b0;
                energized[ch_idx]     <= set_on_q;
                res_ev  <= EV_DONE;
                res_on  <= set_on_q;
                res_chg <= {3'b000, energized[ch_idx] != set_on_q};
              end
            end
            CMD_SET_ALL: begin
              timing_active <= '0;
              energized     <= {CHANNELS{set_on_q}};
              res_ch  <= '0;
              res_ev  <= EV_DONE;
              res_on  <= set_on_q;
              res_chg <= (CNT_BITS > 4 && all_chg > 15) ? 4'd15 : 4'(all_chg);
            end
            CMD_START: begin
              if (ch_valid) begin
                timing_active[ch_idx] <= 1'b1;
                start_ms[ch_idx]      <= now;
                timer_length[ch_idx]  <= dur_q;
                start_level[ch_idx]   <= run_level_q;
                energized[ch_idx]     <= run_level_q;
                res_ev  <= EV_DONE;
                res_on  <= run_level_q;
                res_run <= 1'b1;
                res_rem <= dur_q;
                res_chg <= {3'b000, energized[ch_idx] != run_level_q};
              end
            end
            CMD_TICK: begin
              now   <= now + 1'b1;
              idx   <= '0;
              mask  <= '0;
              state <= S_ELAPSED;
            end
            CMD_STATUS: begin
              if (ch_valid) begin
                res_ev  <= EV_STATUS;
                res_on  <= energized[ch_idx];
                res_run <= timing_active[ch_idx];
                idx     <= ch_idx;
                if (timing_active[ch_idx]) begin
                  state <= S_ELAPSED;
                end
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        S_ELAPSED: begin
          elapsed <= alu_diff[TIME_BITS-1:0];
          state   <= S_DIFF;
        end

        S_DIFF: begin
          if (cmd_q == CMD_TICK) begin
            // expired once the elapsed time has reached the length
            if (timing_active[idx] && (alu_borrow || alu_diff == '0)) begin
              mask[idx] <= 1'b1;
            end
            if (32'(idx) == CHANNELS - 1) begin
              idx   <= '0;
              state <= S_EMIT;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_ELAPSED;
            end
          end else begin
            // clamp at zero once the timer is overdue
            res_rem <= alu_borrow ? 32'd0 : alu_diff[31:0];
            state   <= S_PUSH;
          end
        end

        S_EMIT: begin
          if (mask == '0) begin
            state <= S_IDLE;
          end else if (mask[idx]) begin
            mask[idx]          <= 1'b0;
            timing_active[idx] <= 1'b0;
            energized[idx]     <= ~start_level[idx];
            res_ch    <= 4'(idx);
            res_ev    <= EV_EXPIRED;
            res_on    <= ~start_level[idx];
            res_run   <= 1'b0;
            res_rem   <= '0;
            res_chg   <= {3'b000, energized[idx] == start_level[idx]};
            res_last  <= (mask & ~sel_bit) == '0;
            ret_state <= S_EMIT;
            state     <= S_PUSH;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_PUSH: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_drive <= drive;
            out_ch    <= res_ch;
            out_ev    <= res_ev;
            out_on    <= res_on;
            out_run   <= res_run;
            out_rem   <= res_rem;
            out_chg   <= res_chg;
            out_last  <= res_last;
            state     <= ret_state;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
